/* rtl/feedback_delay_echo_core_assert.svh */
// Assertion macros used by the checker of the echo core.
// Each macro expects a clock named clock and a reset named reset in scope.
`ifndef FEEDBACK_DELAY_ECHO_CORE_ASSERT_SVH
`define FEEDBACK_DELAY_ECHO_CORE_ASSERT_SVH

// Condition holds at every clock edge outside reset.
`define FDE_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define FDE_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FDE_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/fde_pkg.sv */
package fde_pkg;

   // Echo store geometry; the depth is a power of two so pointers wrap naturally
   localparam int STORE_DEPTH = 131072;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int DELAY_W  = 17;
   localparam int GAIN_W   = 16;
   localparam int MIX_W    = 17;

   // Gain limits: feedback at most 0.95, wet share at most unity
   localparam logic [GAIN_W-1:0] FEED_MAX = 16'd62259;
   localparam logic [MIX_W-1:0]  UNITY    = 17'd65536;

   // Register reset values
   localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd12000;
   localparam logic [MIX_W-1:0]   MIX_RESET   = 17'd13763;

   // Output buffer
   localparam int OBUF_DEPTH = 4;
   localparam int OBUF_AW    = $clog2(OBUF_DEPTH);

   // Register file decode
   localparam int CSR_AW = 4;
   localparam logic [1:0] REG_ENABLE   = 2'd0;
   localparam logic [1:0] REG_DELAY    = 2'd1;
   localparam logic [1:0] REG_FEEDBACK = 2'd2;
   localparam logic [1:0] REG_WET_MIX  = 2'd3;

endpackage

/* rtl/feedback_delay_echo_core.sv */
// Channel  | Direction | Ports                                   | Word
// ---------+-----------+-----------------------------------------+------------------------
// req      | in        | req_valid, req_stall, req_sample_in     | one Q2.14 input sample
// rsp      | out       | rsp_valid, rsp_stall, rsp_sample_out    | one Q2.14 mixed sample
// csr      | in/out    | csr_psel .. csr_pready                  | one 32-bit register
//
// One sample per clock sustained while rsp does not stall; a word taken on req passes stage 1,
// stage 2 and the output buffer before it can be taken from rsp.
// The echo store is a single-port-write, single-port-read RAM: one read at accept,
// one write next cycle from stage 1, with a one-entry forward covering read-during-write.
// No clearing pass: a fill mark (pointer plus wrap flag) makes unwritten entries read zero.
// Reset is synchronous; control registers and valid flags return to their reset values.
// A stalled rsp fills a four-word buffer; req stalls while buffer and stages hold four words.
module feedback_delay_echo_core
   import fde_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // input sample channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_in,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample_out,
   // register port
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   // Clamp a wide signed value to the sample range
   function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [35:0] v);
      logic signed [SAMPLE_W-1:0] r;
      if (v > 36'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -36'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[SAMPLE_W-1:0];
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   logic               enable_ff, enable_in;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [GAIN_W-1:0]  feedback_ff, feedback_in;
   logic [MIX_W-1:0]   wet_mix_ff, wet_mix_in;
   logic               csr_wr;
   logic [1:0]         csr_index;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[CSR_AW-1:2];

   // Decode register writes
   always_comb begin
      enable_in   = enable_ff;
      delay_in    = delay_ff;
      feedback_in = feedback_ff;
      wet_mix_in  = wet_mix_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_ENABLE:   enable_in   = csr_pwdata[0];
            REG_DELAY:    delay_in    = csr_pwdata[DELAY_W-1:0];
            REG_FEEDBACK: feedback_in = csr_pwdata[GAIN_W-1:0];
            REG_WET_MIX:  wet_mix_in  = csr_pwdata[MIX_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_index)
         REG_ENABLE:   csr_prdata = {31'd0, enable_ff};
         REG_DELAY:    csr_prdata = 32'(delay_ff);
         REG_FEEDBACK: csr_prdata = 32'(feedback_ff);
         REG_WET_MIX:  csr_prdata = 32'(wet_mix_ff);
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         delay_ff    <= DELAY_RESET;
         feedback_ff <= '0;
         wet_mix_ff  <= MIX_RESET;
      end else begin
         enable_ff   <= enable_in;
         delay_ff    <= delay_in;
         feedback_ff <= feedback_in;
         wet_mix_ff  <= wet_mix_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Accept stage: pointers, read address, fill mark
   // ---------------------------------------------------------------------------
   logic                req_acc;
   logic                echo_acc;
   logic [STORE_AW-1:0] wp_ff, wp_in;
   logic                wrap_ff, wrap_in;
   logic [DELAY_W-1:0]  delay_eff;
   logic [31:0]         delay_wide;
   logic [STORE_AW-1:0] delay_mod;
   logic [STORE_AW-1:0] rp;
   logic                rd_zero;

   assign req_acc  = req_valid & ~req_stall;
   assign echo_acc = req_acc & enable_ff;

   // Zero delay acts as one; take the distance modulo the store depth
   assign delay_eff  = (delay_ff == '0) ? DELAY_W'(1) : delay_ff;
   assign delay_wide = 32'(delay_eff);
   assign delay_mod  = delay_wide[STORE_AW-1:0];
   assign rp         = wp_ff - delay_mod;

   // Entries at or beyond the pointer are unwritten until the first wrap
   assign rd_zero = ~wrap_ff & (rp >= wp_ff);

   // Advance the write pointer with wrap on each echoed word
   always_comb begin
      wp_in   = wp_ff;
      wrap_in = wrap_ff;
      if (echo_acc) begin
         if (wp_ff == STORE_AW'(STORE_DEPTH - 1)) begin
            wp_in   = '0;
            wrap_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         wrap_ff <= 1'b0;
      end else begin
         wp_ff   <= wp_in;
         wrap_ff <= wrap_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: store data arrives, feedback write, mix product
   // ---------------------------------------------------------------------------
   logic                       v1_ff, v1_in;
   logic                       en1_ff, en1_in;
   logic signed [SAMPLE_W-1:0] x1_ff, x1_in;
   logic [STORE_AW-1:0]        rp1_ff, rp1_in;
   logic [STORE_AW-1:0]        wp1_ff, wp1_in;
   logic                       zero1_ff, zero1_in;

   assign v1_in    = req_acc;
   assign en1_in   = enable_ff;
   assign x1_in    = req_sample_in;
   assign rp1_in   = rp;
   assign wp1_in   = wp_ff;
   assign zero1_in = rd_zero;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      en1_ff   <= en1_in;
      x1_ff    <= x1_in;
      rp1_ff   <= rp1_in;
      wp1_ff   <= wp1_in;
      zero1_ff <= zero1_in;
   end

   logic [SAMPLE_W-1:0]        ram_rd_data;
   logic                       ram_wr_en;
   logic signed [SAMPLE_W-1:0] wet;
   logic [GAIN_W-1:0]          fb_c;
   logic [MIX_W-1:0]           wm_c;
   logic signed [32:0]         fb_prod;
   logic signed [17:0]         fb_rnd;
   logic signed [18:0]         stored_sum;
   logic signed [SAMPLE_W-1:0] stored;
   logic signed [16:0]         diff;
   logic signed [34:0]         mix_prod;

   // Forwarding register: last word written to the store
   logic                       fwd_v_ff, fwd_v_in;
   logic [STORE_AW-1:0]        fwd_addr_ff, fwd_addr_in;
   logic signed [SAMPLE_W-1:0] fwd_data_ff, fwd_data_in;

   // Pick the echo word: unwritten reads zero, a just-written entry comes forwarded
   always_comb begin
      if (zero1_ff) begin
         wet = '0;
      end else if (fwd_v_ff && (fwd_addr_ff == rp1_ff)) begin
         wet = fwd_data_ff;
      end else begin
         wet = $signed(ram_rd_data);
      end
   end

   assign fb_c = (feedback_ff > FEED_MAX) ? FEED_MAX : feedback_ff;
   assign wm_c = (wet_mix_ff > UNITY) ? UNITY : wet_mix_ff;

   // Feedback path: round half up, add input, saturate
   assign fb_prod    = 33'($signed(wet) * $signed({1'b0, fb_c}));
   assign fb_rnd     = 18'((34'(fb_prod) + 34'sd32768) >>> 16);
   assign stored_sum = 19'(x1_ff) + 19'(fb_rnd);
   assign stored     = sat16(36'(stored_sum));

   // Mix path: x*(1-wm) + wet*wm rewritten as x*1 + (wet-x)*wm
   assign diff     = 17'(wet) - 17'(x1_ff);
   assign mix_prod = 35'($signed(diff) * $signed({1'b0, wm_c}));

   assign ram_wr_en = v1_ff & en1_ff;

   always_comb begin
      fwd_v_in    = fwd_v_ff;
      fwd_addr_in = fwd_addr_ff;
      fwd_data_in = fwd_data_ff;
      if (ram_wr_en) begin
         fwd_v_in    = 1'b1;
         fwd_addr_in = wp1_ff;
         fwd_data_in = stored;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_v_ff <= 1'b0;
      end else begin
         fwd_v_ff <= fwd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= fwd_addr_in;
      fwd_data_ff <= fwd_data_in;
   end

   fde_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wp1_ff),
      .wr_data (stored),
      .rd_en   (echo_acc),
      .rd_addr (rp),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------
   // Stage 2: round and saturate the mix, or pass the input through
   // ---------------------------------------------------------------------------
   logic                       v2_ff, v2_in;
   logic                       en2_ff, en2_in;
   logic signed [SAMPLE_W-1:0] x2_ff, x2_in;
   logic signed [34:0]         mixp2_ff, mixp2_in;
   logic signed [35:0]         mix_sum;
   logic signed [SAMPLE_W-1:0] rsp_word_in;

   assign v2_in    = v1_ff;
   assign en2_in   = en1_ff;
   assign x2_in    = x1_ff;
   assign mixp2_in = mix_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      en2_ff   <= en2_in;
      x2_ff    <= x2_in;
      mixp2_ff <= mixp2_in;
   end

   assign mix_sum     = (36'(x2_ff) <<< 16) + 36'(mixp2_ff) + 36'sd32768;
   assign rsp_word_in = en2_ff ? sat16(mix_sum >>> 16) : x2_ff;

   // ---------------------------------------------------------------------------
   // Output buffer: hold finished words while rsp stalls
   // ---------------------------------------------------------------------------
   logic signed [SAMPLE_W-1:0] obuf_ff [OBUF_DEPTH];
   logic [OBUF_AW-1:0]         obuf_wp_ff, obuf_wp_in;
   logic [OBUF_AW-1:0]         obuf_rp_ff, obuf_rp_in;
   logic [OBUF_AW:0]           obuf_cnt_ff, obuf_cnt_in;
   logic                       obuf_push, obuf_pop;
   logic [OBUF_AW+1:0]         occupancy;

   assign obuf_push = v2_ff;
   assign obuf_pop  = rsp_valid & ~rsp_stall;

   always_comb begin
      obuf_wp_in  = obuf_push ? obuf_wp_ff + 1'b1 : obuf_wp_ff;
      obuf_rp_in  = obuf_pop ? obuf_rp_ff + 1'b1 : obuf_rp_ff;
      obuf_cnt_in = obuf_cnt_ff + (OBUF_AW+1)'(obuf_push) - (OBUF_AW+1)'(obuf_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_wp_ff  <= '0;
         obuf_rp_ff  <= '0;
         obuf_cnt_ff <= '0;
      end else begin
         obuf_wp_ff  <= obuf_wp_in;
         obuf_rp_ff  <= obuf_rp_in;
         obuf_cnt_ff <= obuf_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (obuf_push) begin
         obuf_ff[obuf_wp_ff] <= rsp_word_in;
      end
   end

   assign rsp_valid      = (obuf_cnt_ff != '0);
   assign rsp_sample_out = obuf_ff[obuf_rp_ff];

   // Stall req once buffered plus in-flight words could overrun the buffer
   assign occupancy = (OBUF_AW+2)'(obuf_cnt_ff) + (OBUF_AW+2)'(v1_ff)
                      + (OBUF_AW+2)'(v2_ff);
   assign req_stall = (occupancy > (OBUF_AW+2)'(OBUF_DEPTH - 1));

endmodule

/* rtl/fde_ram.sv */
module fde_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port; a read of the same entry in the same cycle returns the old word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/fde_checker.sv */
`include "feedback_delay_echo_core_assert.svh"

module fde_checker
   import fde_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out
);

   logic               in_acc;
   logic               out_acc;
   logic [OBUF_AW+1:0] pend_ff, pend_in;

   assign in_acc  = req_valid & ~req_stall;
   assign out_acc = rsp_valid & ~rsp_stall;

   // Track words taken but not yet delivered
   assign pend_in = pend_ff + (OBUF_AW+2)'(in_acc) - (OBUF_AW+2)'(out_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // A stalled result word stays put
   `FDE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_sample_out), "rsp word changed under stall")

   // No result word without an outstanding input word
   `FDE_ASSERT_IMPL(a_no_invent, rsp_valid, pend_ff != '0, "rsp word with nothing pending")

   // Outstanding words never exceed the output buffer
   `FDE_ASSERT_ALWAYS(a_pend_bound, pend_ff <= (OBUF_AW+2)'(OBUF_DEPTH),
      "more words outstanding than buffer space")

   // With nothing pending, a taken word shows on rsp once through both stages and the buffer
   `FDE_ASSERT_IMPL(a_latency, in_acc && (pend_ff == '0), ##3 rsp_valid,
      "result word late on empty pipeline")

endmodule

bind feedback_delay_echo_core fde_checker u_fde_checker (.*);
